// ===== rtl/block_frame_difference_motion_assert.svh =====
// ----------------------------------------------------------------------------
// Block frame-difference motion detector: assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FRAME_DIFFERENCE_MOTION_ASSERT_SVH
`define BLOCK_FRAME_DIFFERENCE_MOTION_ASSERT_SVH
`ifndef SYNTHESIS
`define BFDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_frame_difference_motion: implication failed");
`define BFDM_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("block_frame_difference_motion: forbidden condition seen");
`else
`define BFDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BFDM_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/bfdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Block frame-difference motion detector: package
// Sizes, register codes, gray weights and pipeline stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdm_pkg;

    localparam int MAX_WIDTH         = 1024;
    localparam int MAX_HEIGHT        = 512;
    localparam int MAX_BLOCK_COLUMNS = 128;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int BXA_W   = $clog2(MAX_BLOCK_COLUMNS);
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW    = COL_W + ROW_W;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 10;
    localparam int BW_W       = 9;
    localparam int BH_W       = 9;
    localparam int THR_W      = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int BLK_X_W    = 10;
    localparam int BLK_Y_W    = 9;

    localparam int XE_W   = ((COL_W > BW_W) ? COL_W : BW_W) + 1;
    localparam int YE_W   = ((ROW_W > BH_W) ? ROW_W : BH_W) + 1;
    localparam int DIV_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int REM_W  = (BW_W > BH_W) ? BW_W : BH_W;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam int COEF_W     = 14;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int GRAY_SHIFT = 14;

    localparam logic [COEF_W-1:0] GRAY_COEF_B = 14'd1868;
    localparam logic [COEF_W-1:0] GRAY_COEF_G = 14'd9617;
    localparam logic [COEF_W-1:0] GRAY_COEF_R = 14'd4899;
    localparam logic [PROD_W-1:0] GRAY_ROUND  = 22'd8192;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST    = 11'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST   = 10'd480;
    localparam logic [BW_W-1:0]  BLOCK_WIDTH_RST    = 9'd24;
    localparam logic [BH_W-1:0]  BLOCK_HEIGHT_RST   = 9'd24;
    localparam logic [THR_W-1:0] DIFF_THRESHOLD_RST = 8'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 3'd0,
        CFG_FRAME_HEIGHT   = 3'd1,
        CFG_BLOCK_WIDTH    = 3'd2,
        CFG_BLOCK_HEIGHT   = 3'd3,
        CFG_DIFF_THRESHOLD = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic [BXA_W-1:0] bx;
        logic [COL_W-1:0] base_x;
        logic [ROW_W-1:0] base_y;
        logic             inblk;
        logic             first;
        logic             emit;
    } p1_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod_b;
        logic [PROD_W-1:0] prod_g;
        logic [PROD_W-1:0] prod_r;
        logic [BXA_W-1:0]  bx;
        logic [COL_W-1:0]  base_x;
        logic [ROW_W-1:0]  base_y;
        logic              inblk;
        logic              first;
        logic              emit;
        logic              fwd;
        logic              fwd_mark;
    } p2_t;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/block_frame_difference_motion.sv =====
// ----------------------------------------------------------------------------
// Block frame-difference motion detector
// Takes one item per clock unless stalled by the divider or m_ready; a result
// is registered in p1, p2 and m_valid. Each item makes one read-modify-write
// of the frame store, and one inside a block also of the block mark memory.
// A configuration write holds off input while the block offsets are rebuilt
// one quotient bit a cycle. Reset clears position, block marks and the primed
// flag and loads the default registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_frame_difference_motion_assert.svh"

module block_frame_difference_motion (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [bfdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bfdm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_frame_start,
    input  wire logic [bfdm_pkg::PIX_W-1:0]           s_blue,
    input  wire logic [bfdm_pkg::PIX_W-1:0]           s_green,
    input  wire logic [bfdm_pkg::PIX_W-1:0]           s_red,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [bfdm_pkg::BLK_X_W-1:0]              m_block_x,
    output logic [bfdm_pkg::BLK_Y_W-1:0]              m_block_y,
    output logic                                      m_moving
);

    logic [bfdm_pkg::FW_W-1:0]  frame_width_reg;
    logic [bfdm_pkg::FH_W-1:0]  frame_height_reg;
    logic [bfdm_pkg::BW_W-1:0]  block_width_reg;
    logic [bfdm_pkg::BH_W-1:0]  block_height_reg;
    logic [bfdm_pkg::THR_W-1:0] diff_threshold_reg;

    logic [bfdm_pkg::COL_W:0]   fw_c;
    logic [bfdm_pkg::ROW_W:0]   fh_c;
    logic [bfdm_pkg::BW_W-1:0]  bw_c;
    logic [bfdm_pkg::BH_W-1:0]  bh_c;

    logic [bfdm_pkg::COL_W-1:0] col_reg, col_next;
    logic [bfdm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [bfdm_pkg::BW_W-1:0]  ox_reg, ox_next;
    logic [bfdm_pkg::COL_W-1:0] bx_reg, bx_next;
    logic [bfdm_pkg::BH_W-1:0]  oy_reg, oy_next;
    logic [bfdm_pkg::ROW_W-1:0] by_reg, by_next;
    logic                       primed_reg, primed_next;

    logic                       x_keep, y_keep;
    logic [bfdm_pkg::COL_W-1:0] col;
    logic [bfdm_pkg::ROW_W-1:0] row;
    logic [bfdm_pkg::BW_W-1:0]  ox;
    logic [bfdm_pkg::COL_W-1:0] bx;
    logic [bfdm_pkg::BH_W-1:0]  oy;
    logic [bfdm_pkg::ROW_W-1:0] by;
    logic [bfdm_pkg::COL_W-1:0] base_x;
    logic [bfdm_pkg::ROW_W-1:0] base_y;
    logic [bfdm_pkg::XE_W-1:0]  x_end;
    logic [bfdm_pkg::YE_W-1:0]  y_end;
    logic                       ox_wrap, oy_wrap, col_last, row_last, inblk;
    logic [bfdm_pkg::FRAME_AW-1:0] frame_addr;

    logic                        div_busy_reg;
    logic [bfdm_pkg::DCNT_W-1:0] div_cnt_reg;
    logic                        div_last;
    logic [bfdm_pkg::DIV_W-1:0]  divx_num_reg, divy_num_reg, divx_num_next, divy_num_next;
    logic [bfdm_pkg::REM_W-1:0]  divx_rem_reg, divy_rem_reg, divx_rem_next, divy_rem_next;
    logic [bfdm_pkg::REM_W:0]    divx_sh, divy_sh;
    logic                        divx_q, divy_q;

    logic [3*bfdm_pkg::PIX_W-1:0] frame_mem [bfdm_pkg::FRAME_DEPTH];
    logic [3*bfdm_pkg::PIX_W-1:0] frame_rd_reg;
    logic                         marks_mem [bfdm_pkg::MAX_BLOCK_COLUMNS];
    logic [bfdm_pkg::MAX_BLOCK_COLUMNS-1:0] marks_vld_reg;
    logic                         marks_rd_reg, marks_rdv_reg;

    logic           s_acc;
    logic           p1_v_reg, p2_v_reg;
    bfdm_pkg::p1_t  p1_reg, p1_next;
    bfdm_pkg::p2_t  p2_reg, p2_next;
    logic           p1_go, p1_free, p2_go, p2_free, p2_wr, out_free;
    logic [bfdm_pkg::PIX_W-1:0]  d_b, d_g, d_r;
    logic [bfdm_pkg::PROD_W-1:0] gray_sum;
    logic [bfdm_pkg::PIX_W-1:0]  gray;
    logic                        changed, mark_old, mark_new;

    logic                         m_valid_reg;
    logic [bfdm_pkg::BLK_X_W-1:0] m_block_x_reg;
    logic [bfdm_pkg::BLK_Y_W-1:0] m_block_y_reg;
    logic                         m_moving_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= bfdm_pkg::FRAME_WIDTH_RST;
            frame_height_reg   <= bfdm_pkg::FRAME_HEIGHT_RST;
            block_width_reg    <= bfdm_pkg::BLOCK_WIDTH_RST;
            block_height_reg   <= bfdm_pkg::BLOCK_HEIGHT_RST;
            diff_threshold_reg <= bfdm_pkg::DIFF_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bfdm_pkg::CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[bfdm_pkg::FW_W-1:0];
                end
                bfdm_pkg::CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data[bfdm_pkg::FH_W-1:0];
                end
                bfdm_pkg::CFG_BLOCK_WIDTH: begin
                    block_width_reg <= cfg_data[bfdm_pkg::BW_W-1:0];
                end
                bfdm_pkg::CFG_BLOCK_HEIGHT: begin
                    block_height_reg <= cfg_data[bfdm_pkg::BH_W-1:0];
                end
                bfdm_pkg::CFG_DIFF_THRESHOLD: begin
                    diff_threshold_reg <= cfg_data[bfdm_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            fw_c = (bfdm_pkg::COL_W+1)'(1);
        end else if (int'(frame_width_reg) > bfdm_pkg::MAX_WIDTH) begin
            fw_c = (bfdm_pkg::COL_W+1)'(bfdm_pkg::MAX_WIDTH);
        end else begin
            fw_c = (bfdm_pkg::COL_W+1)'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            fh_c = (bfdm_pkg::ROW_W+1)'(1);
        end else if (int'(frame_height_reg) > bfdm_pkg::MAX_HEIGHT) begin
            fh_c = (bfdm_pkg::ROW_W+1)'(bfdm_pkg::MAX_HEIGHT);
        end else begin
            fh_c = (bfdm_pkg::ROW_W+1)'(frame_height_reg);
        end
        bw_c = (block_width_reg == '0) ? bfdm_pkg::BW_W'(1) : block_width_reg;
        bh_c = (block_height_reg == '0) ? bfdm_pkg::BH_W'(1) : block_height_reg;
    end

    // Position of the incoming item and the position of the one after it.
    always_comb begin
        x_keep = !s_frame_start && ({1'b0, col_reg} < fw_c);
        y_keep = !s_frame_start && ({1'b0, row_reg} < fh_c);
        col    = x_keep ? col_reg : '0;
        ox     = x_keep ? ox_reg : '0;
        bx     = x_keep ? bx_reg : '0;
        row    = y_keep ? row_reg : '0;
        oy     = y_keep ? oy_reg : '0;
        by     = y_keep ? by_reg : '0;

        base_x = col - bfdm_pkg::COL_W'(ox);
        base_y = row - bfdm_pkg::ROW_W'(oy);
        x_end  = bfdm_pkg::XE_W'(base_x) + bfdm_pkg::XE_W'(bw_c);
        y_end  = bfdm_pkg::YE_W'(base_y) + bfdm_pkg::YE_W'(bh_c);
        inblk  = (int'(bx) < bfdm_pkg::MAX_BLOCK_COLUMNS)
                 && (x_end <= bfdm_pkg::XE_W'(fw_c))
                 && (y_end <= bfdm_pkg::YE_W'(fh_c));
        ox_wrap = (ox == bw_c - bfdm_pkg::BW_W'(1));
        oy_wrap = (oy == bh_c - bfdm_pkg::BH_W'(1));
        col_last = !(({1'b0, col} + (bfdm_pkg::COL_W+1)'(1)) < fw_c);
        row_last = !(({1'b0, row} + (bfdm_pkg::ROW_W+1)'(1)) < fh_c);
        frame_addr = {row, col};

        col_next    = col + bfdm_pkg::COL_W'(1);
        ox_next     = ox_wrap ? '0 : ox + bfdm_pkg::BW_W'(1);
        bx_next     = ox_wrap ? bx + bfdm_pkg::COL_W'(1) : bx;
        row_next    = row;
        oy_next     = oy;
        by_next     = by;
        primed_next = primed_reg;
        if (col_last) begin
            col_next = '0;
            ox_next  = '0;
            bx_next  = '0;
            if (row_last) begin
                row_next    = '0;
                oy_next     = '0;
                by_next     = '0;
                primed_next = 1'b1;
            end else begin
                row_next = row + bfdm_pkg::ROW_W'(1);
                oy_next  = oy_wrap ? '0 : oy + bfdm_pkg::BH_W'(1);
                by_next  = oy_wrap ? by + bfdm_pkg::ROW_W'(1) : by;
            end
        end

        p1_next.blue   = s_blue;
        p1_next.green  = s_green;
        p1_next.red    = s_red;
        p1_next.bx     = bfdm_pkg::BXA_W'(bx);
        p1_next.base_x = base_x;
        p1_next.base_y = base_y;
        p1_next.inblk  = inblk;
        p1_next.first  = (ox == '0) && (oy == '0);
        p1_next.emit   = primed_reg && inblk && ox_wrap && oy_wrap;
    end

    // Restoring division rebuilds the block offsets after a register write.
    always_comb begin
        div_last = (div_cnt_reg == bfdm_pkg::DCNT_W'(bfdm_pkg::DIV_W - 1));
        divx_sh  = {divx_rem_reg, divx_num_reg[bfdm_pkg::DIV_W-1]};
        divy_sh  = {divy_rem_reg, divy_num_reg[bfdm_pkg::DIV_W-1]};
        divx_q   = (divx_sh >= (bfdm_pkg::REM_W+1)'(bw_c));
        divy_q   = (divy_sh >= (bfdm_pkg::REM_W+1)'(bh_c));
        divx_rem_next = divx_q ? bfdm_pkg::REM_W'(divx_sh - (bfdm_pkg::REM_W+1)'(bw_c))
                               : bfdm_pkg::REM_W'(divx_sh);
        divy_rem_next = divy_q ? bfdm_pkg::REM_W'(divy_sh - (bfdm_pkg::REM_W+1)'(bh_c))
                               : bfdm_pkg::REM_W'(divy_sh);
        divx_num_next = {divx_num_reg[bfdm_pkg::DIV_W-2:0], divx_q};
        divy_num_next = {divy_num_reg[bfdm_pkg::DIV_W-2:0], divy_q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cfg_wr_en) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            if (div_last) begin
                div_busy_reg <= 1'b0;
            end
            div_cnt_reg <= div_cnt_reg + bfdm_pkg::DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg_wr_en) begin
            divx_num_reg <= bfdm_pkg::DIV_W'(col_reg);
            divy_num_reg <= bfdm_pkg::DIV_W'(row_reg);
            divx_rem_reg <= '0;
            divy_rem_reg <= '0;
        end else if (div_busy_reg) begin
            divx_num_reg <= divx_num_next;
            divy_num_reg <= divy_num_next;
            divx_rem_reg <= divx_rem_next;
            divy_rem_reg <= divy_rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            ox_reg     <= '0;
            bx_reg     <= '0;
            oy_reg     <= '0;
            by_reg     <= '0;
            primed_reg <= 1'b0;
        end else if (div_busy_reg && div_last) begin
            bx_reg <= bfdm_pkg::COL_W'(divx_num_next);
            ox_reg <= bfdm_pkg::BW_W'(divx_rem_next);
            by_reg <= bfdm_pkg::ROW_W'(divy_num_next);
            oy_reg <= bfdm_pkg::BH_W'(divy_rem_next);
        end else if (s_acc) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            ox_reg     <= ox_next;
            bx_reg     <= bx_next;
            oy_reg     <= oy_next;
            by_reg     <= by_next;
            primed_reg <= primed_next;
        end
    end

    // Pipeline flow control.
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        p2_go    = p2_v_reg && (!p2_reg.emit || out_free);
        p2_free  = !p2_v_reg || p2_go;
        p1_go    = p1_v_reg && p2_free;
        p1_free  = !p1_v_reg || p1_go;
        s_ready  = p1_free && !div_busy_reg;
        s_acc    = s_valid && s_ready;
        p2_wr    = p2_go && p2_reg.inblk;
    end

    // Frame store: read-first, so the old pixel comes out as the new one goes in.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            frame_mem[frame_addr] <= {s_red, s_green, s_blue};
            frame_rd_reg          <= frame_mem[frame_addr];
        end
    end

    // Difference and weighting.
    always_comb begin
        d_b = bfdm_pkg::abs_diff(p1_reg.blue,  frame_rd_reg[bfdm_pkg::PIX_W-1:0]);
        d_g = bfdm_pkg::abs_diff(p1_reg.green, frame_rd_reg[2*bfdm_pkg::PIX_W-1:bfdm_pkg::PIX_W]);
        d_r = bfdm_pkg::abs_diff(p1_reg.red,
                                 frame_rd_reg[3*bfdm_pkg::PIX_W-1:2*bfdm_pkg::PIX_W]);
        p2_next.prod_b   = bfdm_pkg::PROD_W'(d_b) * bfdm_pkg::PROD_W'(bfdm_pkg::GRAY_COEF_B);
        p2_next.prod_g   = bfdm_pkg::PROD_W'(d_g) * bfdm_pkg::PROD_W'(bfdm_pkg::GRAY_COEF_G);
        p2_next.prod_r   = bfdm_pkg::PROD_W'(d_r) * bfdm_pkg::PROD_W'(bfdm_pkg::GRAY_COEF_R);
        p2_next.bx       = p1_reg.bx;
        p2_next.base_x   = p1_reg.base_x;
        p2_next.base_y   = p1_reg.base_y;
        p2_next.inblk    = p1_reg.inblk;
        p2_next.first    = p1_reg.first;
        p2_next.emit     = p1_reg.emit;
        p2_next.fwd      = p2_wr && (p2_reg.bx == p1_reg.bx);
        p2_next.fwd_mark = mark_new;
    end

    // Threshold and running mark of the block column.
    always_comb begin
        gray_sum = p2_reg.prod_b + p2_reg.prod_g + p2_reg.prod_r + bfdm_pkg::GRAY_ROUND;
        gray     = gray_sum[bfdm_pkg::PROD_W-1:bfdm_pkg::GRAY_SHIFT];
        changed  = (gray > diff_threshold_reg);
        mark_old = p2_reg.fwd ? p2_reg.fwd_mark : (marks_rdv_reg && marks_rd_reg);
        mark_new = (!p2_reg.first && mark_old) || changed;
    end

    always_ff @(posedge aclk) begin
        if (p2_wr) begin
            marks_mem[p2_reg.bx] <= mark_new;
        end
        if (p1_go) begin
            marks_rd_reg  <= marks_mem[p1_reg.bx];
            marks_rdv_reg <= marks_vld_reg[p1_reg.bx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_vld_reg <= '0;
        end else if (p2_wr) begin
            marks_vld_reg[p2_reg.bx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (p1_free) begin
                p1_v_reg <= s_acc;
            end
            if (p2_free) begin
                p2_v_reg <= p1_go;
            end
            if (out_free) begin
                m_valid_reg <= p2_go && p2_reg.emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_reg <= p1_next;
        end
        if (p1_go) begin
            p2_reg <= p2_next;
        end
        if (p2_go && p2_reg.emit) begin
            m_block_x_reg <= bfdm_pkg::BLK_X_W'(p2_reg.base_x);
            m_block_y_reg <= bfdm_pkg::BLK_Y_W'(p2_reg.base_y);
            m_moving_reg  <= mark_new;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_block_x = m_block_x_reg;
    assign m_block_y = m_block_y_reg;
    assign m_moving  = m_moving_reg;

    `BFDM_ASSERT_IMPLY(a_no_item_while_dividing, aclk, aresetn, div_busy_reg, !s_ready)
    `BFDM_ASSERT_IMPLY(a_offsets_in_block, aclk, aresetn, $fell(div_busy_reg), (ox_reg < bw_c) && (oy_reg < bh_c))
    `BFDM_ASSERT_NEVER(a_no_result_overwrite, aclk, aresetn, p2_go && p2_reg.emit && m_valid_reg && !m_ready)
    `BFDM_ASSERT_IMPLY(a_result_only_when_primed, aclk, aresetn, $rose(m_valid_reg), primed_reg)

endmodule

`default_nettype wire
